@@ rtl/itda_pkg.sv @@
package itda_pkg;

    // Width of the converted word; bits of value above it are ignored.
    localparam int WORD_WIDTH = 64;

    // Decimal digits needed for 2**WORD_WIDTH - 1 (1233/4096 approximates log10(2)).
    localparam int NUM_DIGITS = ((WORD_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
    localparam int CNT_W      = $clog2(WORD_WIDTH);
    localparam int LEN_W      = 5;
    localparam int VALUE_W    = 64;

    localparam logic [3:0] DABBLE_THRESHOLD = 4'd5;
    localparam logic [3:0] DABBLE_OFFSET    = 4'd3;
    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] CHAR_MINUS       = 8'h2D;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               signed_mode;
    } item_t;

    typedef struct packed {
        logic [7:0]       character;
        logic             is_last;
        logic [LEN_W-1:0] total_length;
    } result_t;

    typedef struct packed {
        logic              done;
        logic [NDIG_W-1:0] ndig;
    } dabble_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/itda_dabble.sv @@
module itda_dabble
    import itda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [WORD_WIDTH-1:0] magnitude,
    output logic [BCD_W-1:0]      bcd,
    output dabble_stat_t          stat
);

    logic [WORD_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [NDIG_W-1:0]     ndig_reg, ndig_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [BCD_W-1:0]      adj;
    logic [DIG_IDX_W-1:0]  top_idx;
    logic                  last_step;

    // Add three to every digit of five or more, then shift one bit in.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= DABBLE_THRESHOLD)
                          ? bcd_reg[i*4 +: 4] + DABBLE_OFFSET
                          : bcd_reg[i*4 +: 4];
        end
    end

    assign top_idx   = DIG_IDX_W'(ndig_reg - 1'b1);
    assign last_step = (cnt_reg == CNT_W'(WORD_WIDTH - 1));

    always_comb
    begin
        mag_next    = mag_reg;
        bcd_next    = bcd_reg;
        ndig_next   = ndig_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (load)
        begin
            mag_next    = magnitude;
            bcd_next    = '0;
            ndig_next   = NDIG_W'(1);
            cnt_next    = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            mag_next = {mag_reg[WORD_WIDTH-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], mag_reg[WORD_WIDTH-1]};
            // The top digit overflows into a new digit exactly when its bit 3 is set.
            if ((ndig_reg < NDIG_W'(NUM_DIGITS)) && adj[top_idx*4 + 3])
            begin
                ndig_next = ndig_reg + 1'b1;
            end
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        ndig_reg <= ndig_next;
    end

    assign bcd       = bcd_reg;
    assign stat.done = done_reg;
    assign stat.ndig = ndig_reg;

endmodule

@@ rtl/itda_emit.sv @@
module itda_emit
    import itda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              negative,
    input  logic [NDIG_W-1:0] ndig,
    input  logic [BCD_W-1:0]  bcd,
    output logic              active,
    output logic              strobe,
    output result_t           result
);

    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic                 sign_reg, sign_next;
    logic                 active_reg, active_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 strobe_reg, strobe_next;
    result_t              result_reg, result_next;

    always_comb
    begin
        idx_next    = idx_reg;
        sign_next   = sign_reg;
        active_next = active_reg;
        len_next    = len_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        if (load)
        begin
            idx_next    = DIG_IDX_W'(ndig - 1'b1);
            sign_next   = negative;
            len_next    = LEN_W'(ndig) + LEN_W'(negative);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            strobe_next              = 1'b1;
            result_next.total_length = len_reg;
            if (sign_reg)
            begin
                result_next.character = CHAR_MINUS;
                result_next.is_last   = 1'b0;
                sign_next             = 1'b0;
            end
            else
            begin
                result_next.character = CHAR_ZERO + {4'd0, bcd[idx_reg*4 +: 4]};
                result_next.is_last   = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sign_reg   <= sign_next;
        len_reg    <= len_next;
        result_reg <= result_next;
    end

    assign active = active_reg;
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

@@ rtl/int_to_decimal_ascii.sv @@
// Channel   Handshake               Payload                                  Beat
// --------  ----------------------  ---------------------------------------  ----------------
// input     start high, busy low    item: value, signed_mode                 one word
// result    strobe, one cycle only  result: character, is_last, total_length  one character
//
// From acceptance until busy falls, an item passes through these steps in order: the
// shift-add-3 converter takes one bit of the magnitude per cycle, the digits are handed
// to the character sequencer, the sequencer gives one character per cycle, and the
// control sees the sequencer finish.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
// Reset is asynchronous and active low; it clears the control state only.
module int_to_decimal_ascii
    import itda_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    strobe,
    output result_t result
);

    state_t                state_reg, state_next;
    logic                  neg_reg, neg_next;
    logic [WORD_WIDTH-1:0] word;
    logic                  negative;
    logic [WORD_WIDTH-1:0] magnitude;
    logic                  accept;
    logic                  dabble_load;
    logic                  emit_load;
    logic [BCD_W-1:0]      bcd;
    dabble_stat_t          dstat;
    logic                  emit_active;

    // Only the low WORD_WIDTH bits count. The most negative value negates to itself
    // within the word, which read unsigned is exactly its magnitude.
    assign word      = item.value[WORD_WIDTH-1:0];
    assign negative  = item.signed_mode & word[WORD_WIDTH-1];
    assign magnitude = negative ? (~word + 1'b1) : word;
    assign accept    = start & ~busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (dstat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_active)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = 1'b1;
        dabble_load = 1'b0;
        emit_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                dabble_load = start;
            end
            ST_CONV:
            begin
                emit_load = dstat.done;
            end
            ST_EMIT:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // The sign is kept here until the sequencer takes it with the digits.
    assign neg_next = accept ? negative : neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

    itda_dabble u_dabble
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (dabble_load),
        .magnitude (magnitude),
        .bcd       (bcd),
        .stat      (dstat)
    );

    itda_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit_load),
        .negative (neg_reg),
        .ndig     (dstat.ndig),
        .bcd      (bcd),
        .active   (emit_active),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

@@ sim/itda_text_checker.sv @@
module itda_text_checker
    import itda_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    input  logic    busy,
    input  logic    strobe,
    input  result_t result,
    output int      mismatches,
    output int      chars_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHARS = 20;

    result_t owed_text[$];
    int      mismatch_total = 0;
    int      owed_total     = 0;

    assign mismatches = mismatch_total;
    assign chars_owed = owed_total;

    // Works out the decimal text of one accepted word and queues one character per beat.
    function automatic void queue_decimal_text(input item_t word_in);
        logic [63:0] mask;
        logic [63:0] word;
        logic [63:0] magnitude;
        logic        negative;
        logic [7:0]  rev_digits [MAX_CHARS];
        logic [7:0]  text [MAX_CHARS];
        int          nd;
        int          len;
        int          k;
        result_t     beat;
        mask = '1;
        if (WORD_WIDTH < 64)
            mask = (64'd1 << WORD_WIDTH) - 64'd1;
        word      = word_in.value & mask;
        negative  = word_in.signed_mode && word[WORD_WIDTH-1];
        // Negating within the word gives the exact magnitude of the most negative value.
        magnitude = negative ? ((~word + 64'd1) & mask) : word;
        nd = 0;
        do
        begin
            rev_digits[nd] = CHAR_ZERO + 8'(magnitude % 64'd10);
            magnitude      = magnitude / 64'd10;
            nd++;
        end
        while (magnitude != 64'd0 && nd < MAX_CHARS);
        len = 0;
        if (negative)
        begin
            text[len] = CHAR_MINUS;
            len++;
        end
        for (k = nd - 1; k >= 0 && len < MAX_CHARS; k--)
        begin
            text[len] = rev_digits[k];
            len++;
        end
        for (k = 0; k < len; k++)
        begin
            beat.character    = text[k];
            beat.is_last      = (k == len - 1);
            beat.total_length = LEN_W'(len);
            owed_text.push_back(beat);
        end
    endfunction

    always @(posedge clk)
    begin
        result_t due;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (owed_text.size() == 0)
                begin
                    $display(
                        "%0t: stray beat: expected none, actual char=%02h last=%0b len=%0d",
                        $realtime, result.character, result.is_last, result.total_length);
                    mismatch_total++;
                end
                else
                begin
                    due = owed_text.pop_front();
                    if (result.character !== due.character)
                    begin
                        $display("%0t: character mismatch: expected %02h, actual %02h",
                                 $realtime, due.character, result.character);
                        mismatch_total++;
                    end
                    if (result.is_last !== due.is_last)
                    begin
                        $display("%0t: is_last mismatch: expected %0b, actual %0b",
                                 $realtime, due.is_last, result.is_last);
                        mismatch_total++;
                    end
                    if (result.total_length !== due.total_length)
                    begin
                        $display("%0t: total_length mismatch: expected %0d, actual %0d",
                                 $realtime, due.total_length, result.total_length);
                        mismatch_total++;
                    end
                end
            end
            if (start && !busy)
                queue_decimal_text(item);
            owed_total = owed_text.size();
        end
    end

endmodule

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itda_pkg::*;

    // A healthy block is never quiet for longer than one conversion plus the longest gap
    // between commands.
    localparam int QUIET_LIMIT  = 2000;
    // After the last expected beat, listen for roughly one more conversion in case the
    // block emits characters that nobody asked for.
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_WORDS = 400;
    localparam int MAX_GAP      = 90;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    strobe;
    result_t result;
    int      mismatches;
    int      chars_owed;
    int      quiet_cycles = 0;
    bit      idling_on;

    // Powers of ten up to 10**19, the edges where the digit count changes.
    logic [63:0] decades [20];

    always #1 clk = ~clk;

    int_to_decimal_ascii u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    // The checker watches both channels on its own; this module only drives commands.
    itda_text_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .strobe     (strobe),
        .result     (result),
        .mismatches (mismatches),
        .chars_owed (chars_owed)
    );

    // Watchdog: any accepted command or character beat counts as progress. A run that
    // stalls for too long is declared a failure rather than left to hang.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Issues one conversion command and returns at the rising edge where it is taken.
    // When idling is enabled, about a third of commands are preceded by a pause of random
    // length, so that the pause ends at any point of the previous conversion:
    // during the shift-add-3 pass, during character emission, or after busy has fallen.
    // Without a pause, start simply stays high and the command waits behind busy.
    task automatic send_word(input logic [63:0] value, input logic signed_mode);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(99, 0) < 33)
            gap = $urandom_range(MAX_GAP, 1);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            // The payload wanders while start is low; the block must ignore it.
            item  <= '{value: {$urandom, $urandom}, signed_mode: 1'($urandom)};
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= '{value: value, signed_mode: signed_mode};
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        logic [63:0] value;
        logic        signed_mode;
        int          shape;
        int          shift;
        int          nudge;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        idling_on = 1'b1;
        decades[0] = 64'd1;
        for (int k = 1; k < 20; k++)
            decades[k] = decades[k-1] * 64'd10;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats: zero in both modes, single and double digit edges, the largest
        // unsigned word, minus one, the most negative value read both ways, the largest
        // positive signed value, the 19 to 20 digit boundary, small negatives, and two
        // alternating bit patterns so that every value bit is seen at both levels.
        send_word(64'd0, 1'b0);
        send_word(64'd0, 1'b1);
        send_word(64'd1, 1'b0);
        send_word(64'd1, 1'b1);
        send_word(64'd9, 1'b0);
        send_word(64'd10, 1'b1);
        send_word(64'd99, 1'b1);
        send_word(64'd100, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'h8000_0000_0000_0000, 1'b1);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(decades[19] - 64'd1, 1'b0);
        send_word(decades[19], 1'b0);
        send_word(decades[19], 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFF7, 1'b1);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_word(64'h5555_5555_5555_5555, 1'b1);

        // Random words. Fully random words almost always give 19 or 20 characters, so
        // most words are shortened by a random shift, negated small values, or sit on or one
        // either side of a power of ten, to spread the text length over its whole range.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // A long stretch of back-to-back commands with no pauses at all.
            idling_on   = !(n >= 150 && n < 230);
            shape       = $urandom_range(3, 0);
            signed_mode = 1'($urandom_range(1, 0));
            case (shape)
                0: value = {$urandom, $urandom};
                1:
                begin
                    shift = $urandom_range(63, 0);
                    value = {$urandom, $urandom} >> shift;
                end
                2:
                begin
                    shift       = $urandom_range(63, 0);
                    value       = ~({$urandom, $urandom} >> shift) + 64'd1;
                    signed_mode = 1'b1;
                end
                default:
                begin
                    nudge = $urandom_range(2, 0);
                    value = decades[$urandom_range(19, 0)] + 64'(nudge) - 64'd1;
                end
            endcase
            send_word(value, signed_mode);
        end

        @(negedge clk);
        start <= 1'b0;

        // Wait for every owed character beat, then listen a little longer for strays.
        while (chars_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
